### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert a property during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/skvl_pkg.sv
`default_nettype none
package skvl_pkg;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_LIST   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_FULL     = 3'd1;
   localparam logic [2:0] STATUS_EMPTY    = 3'd2;
   localparam logic [2:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [2:0] STATUS_LISTED   = 3'd4;

   localparam int STR_BYTES = 20;
   localparam int STR_BITS  = 160;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key_high;
      logic [63:0] key_mid;
      logic [31:0] key_low;
      logic [63:0] value_high;
      logic [63:0] value_mid;
      logic [31:0] value_low;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] out_key_high;
      logic [63:0] out_key_mid;
      logic [31:0] out_key_low;
      logic [63:0] out_value_high;
      logic [63:0] out_value_mid;
      logic [31:0] out_value_low;
      logic        last;
   } rsp_type;

   // Cut at the first zero byte and at key_bytes, optionally lower-case letters.
   function automatic logic [STR_BITS-1:0] normalize(
      input logic [STR_BITS-1:0] raw, input logic lower, input int key_bytes);
      logic [STR_BITS-1:0] res;
      logic                ended;
      logic [7:0]          b;
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < STR_BYTES; i++) begin
         b = raw[STR_BITS-1-8*i -: 8];
         if (i >= key_bytes || b == 8'd0) ended = 1'b1;
         if (ended) b = 8'd0;
         else if (lower && b >= 8'h41 && b <= 8'h5a) b = b + 8'h20;
         res[STR_BITS-1-8*i -: 8] = b;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### rtl/core/sorted_key_value_list.sv
`default_nettype none
// Sorted key/value list: up to CAPACITY entries of 20-byte key and value
// strings, held as a singly linked list in a slot memory, ascending by key.
// A command is accepted at a clock edge with start high and busy low; its
// fields arrive on req_item. Insert (kind 0) and delete (kind 1) answer one
// result; list (kind 2) answers one result per entry with last on the final
// one, or a single empty status. Kind 3 is dropped with no result.
// Each result is shown for one cycle with rsp_valid high; the receiver
// cannot stall it, so the block never waits on the output side.
// Insert walks the list to find its place; delete walks it to find the key,
// then, when the last slot is moved into the hole, may walk it again to
// repair the link that pointed at it. List reads each entry and then shows
// it. Every walk step is a read of the slot memories followed by a check of
// the read data (a 160-bit key compare: less-than for insert, equality for
// delete); that read and check pair sets the pace. For kinds 0 to 2, busy
// stays high from the accepting edge until the last result has been shown.
// Reset empties the list (head null, count zero); the slot memory keeps
// its contents, which are never read before they are written.
module sorted_key_value_list #(
   parameter int CAPACITY  = 16,
   parameter int KEY_BYTES = 20
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire skvl_pkg::req_type req_item,
   output logic                   rsp_valid,
   output skvl_pkg::rsp_type      rsp_item
);
   `include "assert_macros.svh"

   localparam int LW = $clog2(CAPACITY + 1); // link width, holds null
   localparam int AW = $clog2(CAPACITY);
   localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_RD      = 4'd1; // issue read of cur
   localparam logic [3:0] ST_CMP     = 4'd2; // compare read data
   localparam logic [3:0] ST_INS_FIN = 4'd3;
   localparam logic [3:0] ST_DEL_FIX = 4'd4; // unlink hit
   localparam logic [3:0] ST_MV_RD   = 4'd5; // read last slot
   localparam logic [3:0] ST_MV_WR   = 4'd6; // copy into hole
   localparam logic [3:0] ST_FX_RD   = 4'd7; // repair walk read
   localparam logic [3:0] ST_FX_CHK  = 4'd8;
   localparam logic [3:0] ST_LS_RD   = 4'd9;
   localparam logic [3:0] ST_LS_OUT  = 4'd10;
   localparam logic [3:0] ST_RESP    = 4'd11;
   localparam logic [3:0] ST_INS_LNK = 4'd12; // point predecessor at new slot

   // Slot memories; key and value rows live together.
   logic [skvl_pkg::STR_BITS-1:0] key_mem [CAPACITY];
   logic [skvl_pkg::STR_BITS-1:0] val_mem [CAPACITY];
   logic [LW-1:0]                 link_mem [CAPACITY];

   logic [3:0]    state_ff, state_in;
   logic [1:0]    kind_ff;
   logic [skvl_pkg::STR_BITS-1:0] key_ff, val_ff;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] cur_ff, cur_in, pre_ff, pre_in, hit_ff, hit_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic [2:0]    status_ff, status_in;
   logic          last_ff, last_in, listed_ff, listed_in;
   logic          rvalid_ff, rvalid_in;
   logic [skvl_pkg::STR_BITS-1:0] out_key_ff, out_val_ff;

   // Memory port: one address, registered read data.
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [skvl_pkg::STR_BITS-1:0] rd_key_ff, rd_val_ff;
   logic [LW-1:0] rd_link_ff;

   // Write port.
   logic          wr_kv, wr_link;
   logic [AW-1:0] wr_addr_kv, wr_addr_link;
   logic [skvl_pkg::STR_BITS-1:0] wr_key, wr_val;
   logic [LW-1:0] wr_link_data;

   logic [LW-1:0] last_slot;
   logic          key_lt, key_eq;

   assign last_slot = count_ff - LW'(1);
   assign key_lt    = rd_key_ff < key_ff;
   assign key_eq    = rd_key_ff == key_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_val_ff  <= val_mem[rd_addr];
         rd_link_ff <= link_mem[rd_addr];
      end
      if (wr_kv) begin
         key_mem[wr_addr_kv] <= wr_key;
         val_mem[wr_addr_kv] <= wr_val;
      end
      if (wr_link) link_mem[wr_addr_link] <= wr_link_data;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      pre_in    = pre_ff;
      hit_in    = hit_ff;
      steps_in  = steps_ff;
      status_in = status_ff;
      last_in   = 1'b1;
      listed_in = 1'b0;
      rvalid_in = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = cur_ff[AW-1:0];
      wr_kv     = 1'b0;
      wr_link   = 1'b0;
      wr_addr_kv   = count_ff[AW-1:0];
      wr_addr_link = cur_ff[AW-1:0];
      wr_key       = key_ff;
      wr_val       = val_ff;
      wr_link_data = cur_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cur_in   = head_ff;
               pre_in   = NULL_LINK;
               steps_in = '0;
               unique case (req_item.kind)
                  skvl_pkg::KIND_INSERT: begin
                     if (count_ff >= LW'(CAPACITY)) begin
                        status_in = skvl_pkg::STATUS_FULL;
                        state_in  = ST_RESP;
                     end else state_in = ST_RD;
                  end
                  skvl_pkg::KIND_DELETE, skvl_pkg::KIND_LIST: begin
                     if (count_ff == '0) begin
                        status_in = skvl_pkg::STATUS_EMPTY;
                        state_in  = ST_RESP;
                     end else if (req_item.kind == skvl_pkg::KIND_LIST)
                        state_in = ST_LS_RD;
                     else state_in = ST_RD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD: begin
            if (steps_ff >= count_ff || cur_ff >= NULL_LINK) begin
               if (kind_ff == skvl_pkg::KIND_INSERT) state_in = ST_INS_FIN;
               else begin
                  status_in = skvl_pkg::STATUS_NOTFOUND;
                  state_in  = ST_RESP;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (kind_ff == skvl_pkg::KIND_INSERT) begin
               if (!key_lt) state_in = ST_INS_FIN;
               else begin
                  pre_in   = cur_ff;
                  cur_in   = rd_link_ff;
                  steps_in = steps_ff + LW'(1);
                  state_in = ST_RD;
               end
            end else begin
               if (key_eq) begin
                  hit_in   = cur_ff;
                  state_in = ST_DEL_FIX;
               end else begin
                  pre_in   = cur_ff;
                  cur_in   = rd_link_ff;
                  steps_in = steps_ff + LW'(1);
                  state_in = ST_RD;
               end
            end
         end
         ST_INS_FIN: begin
            // New entry goes into the next free slot and points at cur.
            wr_kv        = 1'b1;
            wr_link      = 1'b1;
            wr_addr_link = count_ff[AW-1:0];
            wr_link_data = (cur_ff > NULL_LINK) ? NULL_LINK : cur_ff;
            status_in    = skvl_pkg::STATUS_OK;
            if (pre_ff == NULL_LINK) begin
               head_in  = count_ff;
               count_in = count_ff + LW'(1);
               state_in = ST_RESP;
            end else state_in = ST_INS_LNK;
         end
         ST_INS_LNK: begin
            wr_link      = 1'b1;
            wr_addr_link = pre_ff[AW-1:0];
            wr_link_data = count_ff;
            count_in     = count_ff + LW'(1);
            state_in     = ST_RESP;
         end
         ST_DEL_FIX: begin
            // rd_link_ff still holds link of the hit slot.
            if (pre_ff == NULL_LINK) head_in = rd_link_ff;
            else begin
               wr_link      = 1'b1;
               wr_addr_link = pre_ff[AW-1:0];
               wr_link_data = rd_link_ff;
            end
            status_in = skvl_pkg::STATUS_OK;
            if (hit_ff != last_slot) begin
               state_in = ST_MV_RD;
            end else begin
               count_in = count_ff - LW'(1);
               state_in = ST_RESP;
            end
         end
         ST_MV_RD: begin
            rd_en    = 1'b1;
            rd_addr  = last_slot[AW-1:0];
            state_in = ST_MV_WR;
         end
         ST_MV_WR: begin
            wr_kv        = 1'b1;
            wr_addr_kv   = hit_ff[AW-1:0];
            wr_key       = rd_key_ff;
            wr_val       = rd_val_ff;
            wr_link      = 1'b1;
            wr_addr_link = hit_ff[AW-1:0];
            wr_link_data = rd_link_ff;
            steps_in     = '0;
            if (head_ff == last_slot) begin
               head_in  = hit_ff;
               count_in = count_ff - LW'(1);
               state_in = ST_RESP;
            end else begin
               cur_in   = head_ff;
               state_in = ST_FX_RD;
            end
         end
         ST_FX_RD: begin
            if (steps_ff >= count_ff || cur_ff >= NULL_LINK) begin
               count_in = count_ff - LW'(1);
               state_in = ST_RESP;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_FX_CHK;
            end
         end
         ST_FX_CHK: begin
            if (rd_link_ff == last_slot) begin
               wr_link      = 1'b1;
               wr_addr_link = cur_ff[AW-1:0];
               wr_link_data = hit_ff;
               count_in     = count_ff - LW'(1);
               state_in     = ST_RESP;
            end else begin
               cur_in   = rd_link_ff;
               steps_in = steps_ff + LW'(1);
               state_in = ST_FX_RD;
            end
         end
         ST_LS_RD: begin
            rd_en    = 1'b1;
            state_in = ST_LS_OUT;
         end
         ST_LS_OUT: begin
            rvalid_in = 1'b1;
            listed_in = 1'b1;
            status_in = skvl_pkg::STATUS_LISTED;
            last_in   = (steps_ff + LW'(1) == count_ff) || (rd_link_ff >= NULL_LINK);
            cur_in    = rd_link_ff;
            steps_in  = steps_ff + LW'(1);
            state_in  = last_in ? ST_IDLE : ST_LS_RD;
         end
         ST_RESP: begin
            rvalid_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= NULL_LINK;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         kind_ff <= req_item.kind;
         key_ff  <= skvl_pkg::normalize({req_item.key_high, req_item.key_mid,
                                         req_item.key_low}, 1'b1, KEY_BYTES);
         val_ff  <= skvl_pkg::normalize({req_item.value_high, req_item.value_mid,
                                         req_item.value_low}, 1'b0, KEY_BYTES);
      end
      cur_ff    <= cur_in;
      pre_ff    <= pre_in;
      hit_ff    <= hit_in;
      steps_ff  <= steps_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      listed_ff <= listed_in;
      if (state_ff == ST_LS_OUT) begin
         out_key_ff <= rd_key_ff;
         out_val_ff <= rd_val_ff;
      end else begin
         out_key_ff <= '0;
         out_val_ff <= '0;
      end
   end

   // Key and value words pack high, mid, low in the same order as the rows.
   assign rsp_item  = {status_ff, out_key_ff, out_val_ff, last_ff};
   assign rsp_valid = rvalid_ff;
   // Busy until the final result has been shown.
   assign busy = (state_ff != ST_IDLE) || (rvalid_ff && !last_ff);

   `ASSERT_CLK(a_count_range, clock, reset, count_ff <= LW'(CAPACITY),
      "entry count above capacity")
   `ASSERT_CLK(a_listed_status, clock, reset,
      rsp_valid && listed_ff |-> rsp_item.status == skvl_pkg::STATUS_LISTED,
      "listed result without listed status")
   `ASSERT_CLK(a_single_last, clock, reset,
      rsp_valid && rsp_item.status != skvl_pkg::STATUS_LISTED |-> rsp_item.last,
      "single result without last")
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid,
      "result right after reset")
endmodule
`default_nettype wire

### dv/testbench.sv
`default_nettype none
// Self-checking bench for the sorted key/value list. An initial block queues
// commands (a directed part, then random ones), a clocked driver offers them
// with random gaps, and a clocked monitor checks every result strobe against
// a store of expected results computed by a behavioral copy of the list.
module testbench;

   localparam int DEPTH     = 16;
   localparam int NULL_SLOT = DEPTH;
   localparam int STALL_MAX = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   skvl_pkg::req_type req_item = '0;
   wire               busy;
   wire               rsp_valid;
   skvl_pkg::rsp_type rsp_item;

   sorted_key_value_list uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #10 clock = ~clock;

   // Behavioral copy of the list, updated when a command is accepted.
   logic [159:0] slot_key [DEPTH];
   logic [159:0] slot_val [DEPTH];
   int           slot_next [DEPTH];
   int           head = NULL_SLOT;
   int           fill = 0;

   skvl_pkg::req_type pending_cmds[$];
   skvl_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      quiet_phase = 1'b0;

   // Cut a string at its first zero byte and optionally lower-case letters.
   function automatic logic [159:0] clean_string(logic [159:0] raw, bit lower);
      logic [159:0] res;
      logic [7:0]   b;
      bit           ended;
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < 20; i++) begin
         b = raw[159-8*i -: 8];
         if (b == 8'd0) ended = 1'b1;
         if (ended) b = 8'd0;
         else if (lower && b >= "A" && b <= "Z") b = b + 8'd32;
         res[159-8*i -: 8] = b;
      end
      return res;
   endfunction

   function automatic skvl_pkg::rsp_type status_rsp(logic [2:0] st);
      skvl_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   // Apply one accepted command to the list copy and queue its results.
   task automatic apply_command(skvl_pkg::req_type c);
      logic [159:0]      k, v;
      int                now, pre, hit, tail;
      skvl_pkg::rsp_type r;
      k = clean_string({c.key_high, c.key_mid, c.key_low}, 1'b1);
      v = clean_string({c.value_high, c.value_mid, c.value_low}, 1'b0);
      case (c.kind)
         skvl_pkg::KIND_INSERT: begin
            if (fill >= DEPTH) expected_rsps.push_back(status_rsp(skvl_pkg::STATUS_FULL));
            else begin
               slot_key[fill] = k;
               slot_val[fill] = v;
               now = head;
               pre = NULL_SLOT;
               while (now != NULL_SLOT && slot_key[now] < k) begin
                  pre = now;
                  now = slot_next[now];
               end
               slot_next[fill] = now;
               if (pre == NULL_SLOT) head = fill;
               else slot_next[pre] = fill;
               fill++;
               expected_rsps.push_back(status_rsp(skvl_pkg::STATUS_OK));
            end
         end
         skvl_pkg::KIND_DELETE: begin
            if (fill == 0) expected_rsps.push_back(status_rsp(skvl_pkg::STATUS_EMPTY));
            else begin
               now = head;
               pre = NULL_SLOT;
               hit = NULL_SLOT;
               while (now != NULL_SLOT) begin
                  if (slot_key[now] == k) begin
                     hit = now;
                     break;
                  end
                  pre = now;
                  now = slot_next[now];
               end
               if (hit == NULL_SLOT)
                  expected_rsps.push_back(status_rsp(skvl_pkg::STATUS_NOTFOUND));
               else begin
                  if (pre == NULL_SLOT) head = slot_next[hit];
                  else slot_next[pre] = slot_next[hit];
                  // The highest occupied slot moves into the hole.
                  tail = fill - 1;
                  if (hit != tail) begin
                     slot_key[hit]  = slot_key[tail];
                     slot_val[hit]  = slot_val[tail];
                     slot_next[hit] = slot_next[tail];
                     if (head == tail) head = hit;
                     else begin
                        now = head;
                        while (now != NULL_SLOT) begin
                           if (slot_next[now] == tail) begin
                              slot_next[now] = hit;
                              break;
                           end
                           now = slot_next[now];
                        end
                     end
                  end
                  fill--;
                  expected_rsps.push_back(status_rsp(skvl_pkg::STATUS_OK));
               end
            end
         end
         skvl_pkg::KIND_LIST: begin
            if (fill == 0) expected_rsps.push_back(status_rsp(skvl_pkg::STATUS_EMPTY));
            else begin
               now = head;
               while (now != NULL_SLOT) begin
                  r = '0;
                  r.status = skvl_pkg::STATUS_LISTED;
                  {r.out_key_high, r.out_key_mid, r.out_key_low} = slot_key[now];
                  {r.out_value_high, r.out_value_mid, r.out_value_low} = slot_val[now];
                  now = slot_next[now];
                  r.last = (now == NULL_SLOT);
                  expected_rsps.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Driver: offers the next queued command, idling at random outside the
   // quiet phase. start stays high across back-to-back commands, and a
   // command is only consumed once busy is seen low at the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            apply_command(req_item);
            idle_cycles = 0;
         end
         if ((!start || !busy) && pending_cmds.size() > 0
             && (quiet_phase || $urandom_range(99) >= 6)) begin
            start    <= 1'b1;
            req_item <= pending_cmds.pop_front();
         end else if (!start || !busy) begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe must match the oldest expected result.
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (rsp_valid) begin
            idle_cycles = 0;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_item);
               errors++;
            end else begin
               if (rsp_item !== expected_rsps[0]) begin
                  $display("%0t: mismatch expected %h actual %h", $time,
                           expected_rsps[0], rsp_item);
                  errors++;
               end
               void'(expected_rsps.pop_front());
            end
         end
         if (idle_cycles > STALL_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Keys come from a small alphabet so that hits, duplicates and case
   // folding happen often; a few are fully random bit patterns.
   function automatic logic [159:0] pick_key();
      logic [159:0] s;
      int           n;
      s = '0;
      if ($urandom_range(9) == 0) begin
         for (int i = 0; i < 5; i++) s[32*i +: 32] = $urandom;
         return s;
      end
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
         s[159-8*i -: 8] = 8'((($urandom_range(1) != 0) ? "a" : "A")
                              + $urandom_range(2));
      return s;
   endfunction

   function automatic skvl_pkg::req_type make_cmd(logic [1:0] kind, logic [159:0] k,
                                                  logic [159:0] v);
      skvl_pkg::req_type c;
      c.kind = kind;
      {c.key_high, c.key_mid, c.key_low} = k;
      {c.value_high, c.value_mid, c.value_low} = v;
      return c;
   endfunction

   function automatic logic [159:0] rand160();
      logic [159:0] s;
      for (int i = 0; i < 5; i++) s[32*i +: 32] = $urandom;
      return s;
   endfunction

   initial begin
      logic [1:0] kind;
      int         roll;
      // Directed part: empty cases, extremes, case folding, fill to full.
      // Short strings are left aligned so that byte 0 is their first letter.
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_LIST, '0, '0));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_DELETE, {"abc", 136'd0}, '0));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_UNUSED, rand160(), rand160()));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_INSERT, {160{1'b1}}, {160{1'b1}}));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_INSERT, '0, '0));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_INSERT, {"ABC", 136'd0},
                                      {"Val", 136'd0}));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_INSERT, {"abc", 136'd0},
                                      {"x", 8'h0, "junk", 112'd0}));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_INSERT, {"Q", 8'h0, "zz", 128'd0},
                                      rand160()));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_LIST, '0, '0));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_DELETE, {"xyz", 136'd0}, '0));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_DELETE, {"aBc", 136'd0}, '0));
      for (int i = 0; i < 12; i++)
         pending_cmds.push_back(make_cmd(skvl_pkg::KIND_INSERT, pick_key(), rand160()));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_LIST, '0, '0));
      pending_cmds.push_back(make_cmd(skvl_pkg::KIND_DELETE, '0, '0));

      // Random part: weighted so the list swings between empty and full.
      for (int i = 0; i < 410; i++) begin
         roll = $urandom_range(99);
         if (i % 120 < 60)
            kind = roll < 55 ? skvl_pkg::KIND_INSERT : roll < 85 ? skvl_pkg::KIND_DELETE
                 : roll < 97 ? skvl_pkg::KIND_LIST : skvl_pkg::KIND_UNUSED;
         else
            kind = roll < 30 ? skvl_pkg::KIND_INSERT : roll < 85 ? skvl_pkg::KIND_DELETE
                 : roll < 97 ? skvl_pkg::KIND_LIST : skvl_pkg::KIND_UNUSED;
         pending_cmds.push_back(make_cmd(kind, pick_key(), rand160()));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A stretch with no idling at all in the middle of the run.
      wait (pending_cmds.size() < 250);
      quiet_phase = 1'b1;
      wait (pending_cmds.size() < 150);
      quiet_phase = 1'b0;

      wait (pending_cmds.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

### sorted_key_value_list.f
+incdir+rtl/core
rtl/core/skvl_pkg.sv
rtl/core/sorted_key_value_list.sv
dv/testbench.sv
